[hdl/csvx_pkg.sv]
`default_nettype none

package csvx_pkg;

	// Default store capacity of one cell, in bytes.
	localparam int CELL_CAPACITY_DEF = 32;

	// Position width that covers every legal capacity, up to 64 bytes.
	localparam int POS_W = 7;

	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;

	localparam logic [7:0] SEP_RESET  = 8'd44;
	localparam logic       TRIM_RESET = 1'b1;

	typedef enum logic [0:0] {
		CFG_FIELD_SEP = 1'b0,
		CFG_TRIM_EN   = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_QUOTE = 2'd1,
		ST_EARLY_END = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	// One finished cell or one error, handed from the parser to the replay side.
	typedef struct packed {
		logic             err;
		status_t          status;
		logic             empty;
		logic             bank;
		logic [POS_W-1:0] lo;
		logic [POS_W-1:0] hi;
		logic [7:0]       count;
	} job_t;

	typedef struct packed {
		logic             en;
		logic             bank;
		logic [POS_W-1:0] idx;
		logic [7:0]       data;
	} mem_wr_t;

	typedef struct packed {
		logic en;
		logic bank;
	} release_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB);
	endfunction

endpackage

`default_nettype wire

[hdl/csvx_front.sv]
`default_nettype none

module csvx_front import csvx_pkg::*; #(
	parameter int CELL_CAPACITY = CELL_CAPACITY_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       last_column,
	input  wire logic       end_of_data,
	input  wire logic [7:0] field_sep,
	input  wire logic       trim_en,
	output job_t            job,
	output logic            job_valid,
	input  wire logic       job_ready,
	output mem_wr_t         mem_wr,
	input  release_t        rel
);

	localparam int LEN_W = $clog2(CELL_CAPACITY + 1);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_COLLECT,
		PH_ESCAPE,
		PH_AFTERQ
	} phase_t;

	phase_t           phase_q, phase_d;
	logic             quoted_q, quoted_d;
	logic [7:0]       term_q, term_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic [7:0]       cnt_q, cnt_d;
	logic             has_q, has_d;
	logic [POS_W-1:0] lo_q, lo_d, hi_q, hi_d;
	logic             bank_q;
	logic [1:0]       busy_q, busy_d;

	logic             accept;
	logic [7:0]       cnt_inc, want;
	logic [7:0]       eff_term;
	logic             eff_quoted, eff_has;
	logic [LEN_W-1:0] eff_len;
	logic             collect_en, store_en, push_cell, push_err, do_clear;
	status_t          err_code;
	logic [7:0]       cell_cnt;

	assign in_ready = !busy_q[bank_q] && job_ready;
	assign accept   = in_valid && in_ready;
	assign cnt_inc  = cnt_q + 8'd1;
	assign want     = last_column ? CH_NL : field_sep;

	// A new cell starts from an empty store; its terminator is chosen here for unquoted cells.
	assign eff_len    = (phase_q == PH_IDLE) ? '0 : len_q;
	assign eff_has    = (phase_q == PH_IDLE) ? 1'b0 : has_q;
	assign eff_quoted = (phase_q == PH_IDLE) ? 1'b0 : quoted_q;
	assign eff_term   = (phase_q == PH_IDLE) ? want : term_q;

	always_comb begin
		phase_d    = phase_q;
		quoted_d   = quoted_q;
		term_d     = term_q;
		len_d      = len_q;
		cnt_d      = cnt_q;
		has_d      = has_q;
		lo_d       = lo_q;
		hi_d       = hi_q;
		collect_en = 1'b0;
		store_en   = 1'b0;
		push_cell  = 1'b0;
		push_err   = 1'b0;
		err_code   = ST_OK;
		cell_cnt   = cnt_inc;
		mem_wr     = '0;

		if (accept) begin
			if (end_of_data) begin
				cell_cnt = cnt_q;
				if (phase_q == PH_COLLECT) begin
					push_cell = 1'b1;
				end else begin
					push_err = 1'b1;
					err_code = ST_EARLY_END;
				end
			end else begin
				cnt_d = cnt_inc;
				len_d = eff_len;
				has_d = eff_has;
				unique case (phase_q)
					PH_IDLE: begin
						phase_d = PH_COLLECT;
						if (in_byte == CH_DQUOTE) begin
							quoted_d = 1'b1;
							term_d   = CH_DQUOTE;
						end else begin
							quoted_d   = 1'b0;
							term_d     = want;
							collect_en = 1'b1;
						end
					end
					PH_COLLECT: collect_en = 1'b1;
					PH_ESCAPE: begin
						phase_d  = PH_COLLECT;
						store_en = 1'b1;
					end
					PH_AFTERQ: begin
						if (in_byte != want) begin
							push_err = 1'b1;
							err_code = ST_BAD_QUOTE;
						end else begin
							push_cell = 1'b1;
						end
					end
					default: phase_d = PH_IDLE;
				endcase

				if (collect_en) begin
					if (in_byte == eff_term) begin
						if (eff_quoted) begin
							phase_d = PH_AFTERQ;
						end else begin
							push_cell = 1'b1;
						end
					end else if (in_byte == CH_BSLASH) begin
						phase_d = PH_ESCAPE;
					end else begin
						store_en = 1'b1;
					end
				end

				if (store_en) begin
					if (eff_len >= LEN_W'(CELL_CAPACITY)) begin
						push_err = 1'b1;
						err_code = ST_OVERFLOW;
					end else begin
						mem_wr.en   = 1'b1;
						mem_wr.bank = bank_q;
						mem_wr.idx  = POS_W'(eff_len);
						mem_wr.data = in_byte;
						len_d       = eff_len + LEN_W'(1);
						// Trim bounds track the first and last non-blank bytes.
						if (!is_blank(in_byte)) begin
							if (!eff_has) begin
								lo_d = POS_W'(eff_len);
							end
							hi_d  = POS_W'(eff_len) + POS_W'(1);
							has_d = 1'b1;
						end
					end
				end
			end
		end

		do_clear = push_cell || push_err;
		if (do_clear) begin
			phase_d  = PH_IDLE;
			quoted_d = 1'b0;
			term_d   = '0;
			len_d    = '0;
			cnt_d    = '0;
			has_d    = 1'b0;
		end

		// A closing or failed cell claims its bank; the replay side hands it back when done.
		busy_d = busy_q;
		if (rel.en) begin
			busy_d[rel.bank] = 1'b0;
		end
		if (do_clear) begin
			busy_d[bank_q] = 1'b1;
		end
	end

	always_comb begin
		job        = '0;
		job.bank   = bank_q;
		job_valid  = push_cell || push_err;
		if (push_err) begin
			job.err    = 1'b1;
			job.status = err_code;
			job.empty  = 1'b1;
		end else begin
			job.status = ST_OK;
			job.count  = cell_cnt;
			if (trim_en) begin
				job.empty = !eff_has;
				job.lo    = lo_q;
				job.hi    = hi_q;
			end else begin
				job.empty = (eff_len == '0);
				job.lo    = '0;
				job.hi    = POS_W'(eff_len);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			quoted_q <= 1'b0;
			term_q   <= '0;
			len_q    <= '0;
			cnt_q    <= '0;
			has_q    <= 1'b0;
			lo_q     <= '0;
			hi_q     <= '0;
			bank_q   <= 1'b0;
			busy_q   <= '0;
		end else begin
			phase_q  <= phase_d;
			quoted_q <= quoted_d;
			term_q   <= term_d;
			len_q    <= len_d;
			cnt_q    <= cnt_d;
			has_q    <= has_d;
			lo_q     <= lo_d;
			hi_q     <= hi_d;
			busy_q   <= busy_d;
			if (do_clear) begin
				bank_q <= !bank_q;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/csvx_jobq.sv]
`default_nettype none

module csvx_jobq import csvx_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  job_t      push_data,
	input  wire logic push_valid,
	output logic      push_ready,
	output job_t      pop_data,
	output logic      pop_valid,
	input  wire logic pop_ready
);

	job_t       data_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	logic       do_push, do_pop;

	assign push_ready = (fill_q != 2'd2);
	assign pop_valid  = (fill_q != 2'd0);
	assign pop_data   = data_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

[hdl/csvx_back.sv]
`default_nettype none

module csvx_back import csvx_pkg::*; #(
	parameter int CELL_CAPACITY = CELL_CAPACITY_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  mem_wr_t    mem_wr,
	input  job_t       job,
	input  wire logic  job_valid,
	output logic       job_pop,
	output release_t   rel,
	output logic       out_valid,
	input  wire logic  out_ready,
	output logic [7:0] out_byte,
	output logic       cell_empty,
	output logic       last,
	output logic [1:0] status,
	output logic [7:0] consumed_count
);

	localparam int IDX_W     = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
	localparam int MEM_DEPTH = 2 << IDX_W;

	typedef enum logic {
		B_IDLE,
		B_RUN
	} bstate_t;

	logic [7:0]       mem [MEM_DEPTH];
	bstate_t          state_q;
	logic             bank_q;
	logic [POS_W-1:0] idx_q, hi_q, idx_inc;
	logic [7:0]       cnt_q;
	logic             out_valid_q, empty_q, last_q;
	status_t          status_q;
	logic [7:0]       count_q, byte_q;
	logic             out_free, single, rd_en, run_last;

	assign out_free = !out_valid_q || out_ready;
	assign job_pop  = (state_q == B_IDLE) && job_valid && out_free;
	assign single   = job.err || job.empty;
	assign rd_en    = (state_q == B_RUN) && out_free;
	assign idx_inc  = idx_q + POS_W'(1);
	assign run_last = (idx_inc == hi_q);

	always_comb begin
		rel = '0;
		if (job_pop && single) begin
			rel.en   = 1'b1;
			rel.bank = job.bank;
		end else if (rd_en && run_last) begin
			rel.en   = 1'b1;
			rel.bank = bank_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			mem[{mem_wr.bank, mem_wr.idx[IDX_W-1:0]}] <= mem_wr.data;
		end
		if (rd_en) begin
			byte_q <= mem[{bank_q, idx_q[IDX_W-1:0]}];
		end else if (job_pop && single) begin
			byte_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			bank_q      <= 1'b0;
			idx_q       <= '0;
			hi_q        <= '0;
			cnt_q       <= '0;
			empty_q     <= 1'b0;
			last_q      <= 1'b0;
			status_q    <= ST_OK;
			count_q     <= '0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_IDLE: begin
					if (job_pop) begin
						if (single) begin
							out_valid_q <= 1'b1;
							empty_q     <= 1'b1;
							last_q      <= 1'b1;
							status_q    <= job.status;
							count_q     <= job.count;
						end else begin
							state_q <= B_RUN;
							bank_q  <= job.bank;
							idx_q   <= job.lo;
							hi_q    <= job.hi;
							cnt_q   <= job.count;
						end
					end
				end
				B_RUN: begin
					if (rd_en) begin
						out_valid_q <= 1'b1;
						empty_q     <= 1'b0;
						last_q      <= run_last;
						status_q    <= ST_OK;
						count_q     <= cnt_q;
						idx_q       <= idx_inc;
						if (run_last) begin
							state_q <= B_IDLE;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = byte_q;
	assign cell_empty     = empty_q;
	assign last           = last_q;
	assign status         = status_q;
	assign consumed_count = count_q;

endmodule

`default_nettype wire

[hdl/csv_cell_extractor.sv]
// CSV cell extractor. Text enters one byte per request on the input channel, with
// last_column telling whether the cell ends at a newline instead of the field
// separator, and end_of_data marking the end of the buffer (no byte carried). A
// cell that opens with a double quote runs to the next unescaped quote, which must
// be followed by the terminator; a backslash takes the next byte literally. Each
// finished cell comes out as a burst of result requests, one stored byte each,
// trimmed of leading and trailing spaces and tabs when trim_enable is set; an
// empty cell or an error gives a single request with cell_empty set. Timing: the
// parser takes one byte per cycle unless stalled. A cell's bytes go into one of two
// store banks, so the next cell is collected while the previous one is replayed.
// Replay starts with a step that takes the descriptor and then reads one byte per
// cycle from the store's single read port while the output is not stalled. Input
// stalls while the parser's bank is in replay or the descriptor queue is full.
// Configuration writes are always accepted and should be made while idle.
`default_nettype none

module csv_cell_extractor import csvx_pkg::*; #(
	parameter int CELL_CAPACITY = CELL_CAPACITY_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// Configuration write channel.
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [0:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	// Input byte channel.
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       last_column,
	input  wire logic       end_of_data,
	// Result channel.
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            cell_empty,
	output logic            last,
	output logic [1:0]      status,
	output logic [7:0]      consumed_count
);

	logic [7:0] sep_q;
	logic       trim_q;

	job_t       push_job, pop_job;
	logic       push_valid, push_ready, pop_valid, pop_ready;
	mem_wr_t    mem_wr;
	release_t   rel;

	// The register file never stalls a write request.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q  <= SEP_RESET;
			trim_q <= TRIM_RESET;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FIELD_SEP: sep_q  <= cfg_data;
				CFG_TRIM_EN:   trim_q <= cfg_data[0];
				default:       sep_q  <= sep_q;
			endcase
		end
	end

	// The parser classifies each byte, writes kept bytes into the current bank and
	// posts a descriptor with its byte bounds when a cell closes, or its status when it fails.
	csvx_front #(
		.CELL_CAPACITY(CELL_CAPACITY)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_byte     (in_byte),
		.last_column (last_column),
		.end_of_data (end_of_data),
		.field_sep   (sep_q),
		.trim_en     (trim_q),
		.job         (push_job),
		.job_valid   (push_valid),
		.job_ready   (push_ready),
		.mem_wr      (mem_wr),
		.rel         (rel)
	);

	// Two descriptors of queue decouple the parser from the replay side.
	csvx_jobq u_jobq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_data  (push_job),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.pop_data   (pop_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready)
	);

	// The replay side owns the cell store and walks each descriptor's byte range,
	// handing the bank back after the last read, or at once for empty or failed cells.
	csvx_back #(
		.CELL_CAPACITY(CELL_CAPACITY)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.mem_wr         (mem_wr),
		.job            (pop_job),
		.job_valid      (pop_valid),
		.job_pop        (pop_ready),
		.rel            (rel),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.out_byte       (out_byte),
		.cell_empty     (cell_empty),
		.last           (last),
		.status         (status),
		.consumed_count (consumed_count)
	);

endmodule

`default_nettype wire
